FILE: rtl/format_string_expander_macros.svh
// ---------------------------------------------------------------------------
// format_string_expander assertion macros
// Shared concurrent assertion forms for the formatter RTL.
// ---------------------------------------------------------------------------
`ifndef FORMAT_STRING_EXPANDER_MACROS_SVH
`define FORMAT_STRING_EXPANDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FSE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format_string_expander: check failed");

// next-cycle implication, disabled while in reset
`define FSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format_string_expander: check failed");

`endif

FILE: rtl/fse_pkg.sv
// ---------------------------------------------------------------------------
// fse_pkg
// Word types, opcodes, character codes and helpers for the formatter.
// ---------------------------------------------------------------------------
package fse_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ARG_W   = 32;
    localparam int COUNT_W = 16;
    localparam int NIB_W   = 4;

    // input opcodes
    localparam logic [OP_W-1:0] OP_FMT  = 2'd0;
    localparam logic [OP_W-1:0] OP_STR  = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PCT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_D   = 8'h64;
    localparam logic [CHAR_W-1:0] CH_P   = 8'h70;
    localparam logic [CHAR_W-1:0] CH_S   = 8'h73;
    localparam logic [CHAR_W-1:0] CH_LX  = 8'h78;

    localparam logic [NIB_W-1:0] NIB_NINE = 4'd9;
    localparam logic [NIB_W-1:0] NIB_TEN  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_in;
        logic [ARG_W-1:0]  arg_value;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               run_last;
        logic [COUNT_W-1:0] out_count;
    } t_out_word;

    // one character handed from the sequencer to the output stage
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              clr;   // end marker: restart count afterwards
    } t_emit;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        return (nib <= NIB_NINE) ? (CH_0 + {4'd0, nib}) : (CH_A + {4'd0, nib - NIB_TEN});
    endfunction

    function automatic logic [CHAR_W-1:0] dec_char(input logic [NIB_W-1:0] dig);
        return CH_0 + {4'd0, dig};
    endfunction

endpackage

FILE: rtl/format_string_expander.sv
// ---------------------------------------------------------------------------
// format_string_expander: plain chars, non-NUL string bytes and end words give one word
// each in the cycle after acceptance, 1/cycle unless the output stalls. %x/%X/%p: one hex
// digit per cycle unless the output stalls, input stalled meanwhile. %d: BCD conversion,
// then DIG_N digits with leading zeros dropped. Sync reset clears state and counters only.
// ---------------------------------------------------------------------------
`include "format_string_expander_macros.svh"

module format_string_expander #(
    parameter int HEX_DIGITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fse_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fse_pkg::t_out_word o_out_data
);

    import fse_pkg::*;

    localparam int VAL_W  = (VALUE_BITS < ARG_W) ? VALUE_BITS : ARG_W;
    localparam int DIG_N  = ((VAL_W * 1233) >> 12) + 1;
    localparam int HEX_W  = HEX_DIGITS * NIB_W;
    localparam int DEC_W  = DIG_N * NIB_W;
    localparam int HCNT_W = $clog2(HEX_DIGITS + 1);
    localparam int DCNT_W = $clog2(DIG_N + 1);
    localparam logic [HCNT_W-1:0] HCNT_LOAD = HCNT_W'(HEX_DIGITS);
    localparam logic [HCNT_W-1:0] HCNT_ONE  = HCNT_W'(1);
    localparam logic [DCNT_W-1:0] DCNT_LOAD = DCNT_W'(DIG_N);
    localparam logic [DCNT_W-1:0] DCNT_ONE  = DCNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEX,
        S_BCD,
        S_DEC
    } t_state;

    t_state            r_state;
    logic              r_pending;
    logic [HEX_W-1:0]  r_hsh;
    logic [HCNT_W-1:0] r_hcnt;
    logic [DEC_W-1:0]  r_dsh;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_lead;

    logic               in_acc;
    logic [CHAR_W-1:0]  ch;
    logic [VAL_W-1:0]   val;
    logic [HEX_W+VAL_W-1:0] hex_ext;
    logic               is_hex;
    logic               is_dec;
    logic               is_str;
    logic               em_valid;
    t_emit              em;
    logic               em_rdy;
    logic               skip;
    logic [NIB_W-1:0]   dec_top;
    logic               bcd_start;
    logic               bcd_done;
    logic [DEC_W-1:0]   bcd;
    logic               out_mid;
    logic               seq_busy;
    logic               bcd_fin;

    assign ch      = i_in_data.char_in;
    assign val     = i_in_data.arg_value[VAL_W-1:0];
    assign hex_ext = {{HEX_W{1'b0}}, val};
    assign is_hex  = (ch == CH_LX) || (ch == CH_UX) || (ch == CH_P);
    assign is_dec  = (ch == CH_D);
    assign is_str  = (ch == CH_S);
    assign dec_top = r_dsh[DEC_W-1 -: NIB_W];

    assign o_in_stall = !((r_state == S_IDLE) && em_rdy);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign bcd_start  = in_acc && (i_in_data.op == OP_FMT) && r_pending && is_dec;

    // character select for the output stage
    always_comb begin
        em_valid = 1'b0;
        em.ch    = CH_NUL;
        em.last  = 1'b1;
        em.clr   = 1'b0;
        skip     = 1'b0;
        case (r_state)
            S_IDLE: begin
                em.ch = ch;
                case (i_in_data.op)
                    OP_FMT: begin
                        if (!r_pending) begin
                            em_valid = i_in_valid && (ch != CH_PCT);
                        end else begin
                            em_valid = i_in_valid && !is_hex && !is_dec && !is_str;
                        end
                    end
                    OP_STR: begin
                        em_valid = i_in_valid && (ch != CH_NUL);
                    end
                    OP_END: begin
                        em_valid = i_in_valid;
                        em.ch    = CH_NUL;
                        em.clr   = 1'b1;
                    end
                    default: begin
                        em_valid = 1'b0;
                    end
                endcase
            end
            S_HEX: begin
                em_valid = 1'b1;
                em.ch    = hex_char(r_hsh[HEX_W-1 -: NIB_W]);
                em.last  = (r_hcnt == HCNT_ONE);
            end
            S_DEC: begin
                // leading zeros are dropped; the final digit always goes out
                skip     = r_lead && (dec_top == '0) && (r_dcnt != DCNT_ONE);
                em_valid = !skip;
                em.ch    = dec_char(dec_top);
                em.last  = (r_dcnt == DCNT_ONE);
            end
            default: begin
                em_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_hcnt    <= '0;
            r_dcnt    <= '0;
            r_lead    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.op)
                            OP_FMT: begin
                                if (!r_pending) begin
                                    r_pending <= (ch == CH_PCT);
                                end else begin
                                    r_pending <= 1'b0;
                                    if (is_hex) begin
                                        r_hsh   <= hex_ext[HEX_W-1:0];
                                        r_hcnt  <= HCNT_LOAD;
                                        r_state <= S_HEX;
                                    end else if (is_dec) begin
                                        r_state <= S_BCD;
                                    end
                                end
                            end
                            OP_END: begin
                                r_pending <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_HEX: begin
                    if (em_rdy) begin
                        r_hsh  <= {r_hsh[HEX_W-NIB_W-1:0], {NIB_W{1'b0}}};
                        r_hcnt <= r_hcnt - HCNT_ONE;
                        if (em.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_BCD: begin
                    if (bcd_done) begin
                        r_dsh   <= bcd;
                        r_dcnt  <= DCNT_LOAD;
                        r_lead  <= 1'b1;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (skip || em_rdy) begin
                        r_dsh  <= {r_dsh[DEC_W-NIB_W-1:0], {NIB_W{1'b0}}};
                        r_dcnt <= r_dcnt - DCNT_ONE;
                        if (!skip) begin
                            r_lead <= 1'b0;
                            if (em.last) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    fse_bcd #(
        .VAL_W (VAL_W),
        .DIG_N (DIG_N)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_value (val),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    fse_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_em_valid (em_valid),
        .i_em       (em),
        .o_em_rdy   (em_rdy),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

    assign out_mid  = o_out_valid && !o_out_data.run_last;
    assign seq_busy = (r_state == S_HEX) || (r_state == S_DEC);
    assign bcd_fin  = (r_state == S_BCD) && bcd_done;

    // a non-final word waiting at the output means the sequencer still owes digits
    `FSE_ASSERT_IMPL(a_nonlast_busy, i_clk, i_rst_n, out_mid, seq_busy)
    `FSE_ASSERT_NEXT(a_bcd_to_dec, i_clk, i_rst_n, bcd_fin, r_state == S_DEC && r_lead)
    `FSE_ASSERT_IMPL(a_dec_cnt_live, i_clk, i_rst_n, r_state == S_DEC, r_dcnt != '0)
    `FSE_ASSERT_IMPL(a_hex_cnt_live, i_clk, i_rst_n, r_state == S_HEX, r_hcnt != '0)

endmodule

FILE: rtl/fse_bcd.sv
// ---------------------------------------------------------------------------
// fse_bcd
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// ---------------------------------------------------------------------------
module fse_bcd #(
    parameter int VAL_W = 32,
    parameter int DIG_N = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_done,
    output logic [DIG_N*4-1:0] o_bcd
);

    localparam int CNT_W = $clog2(VAL_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VAL_W);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [3:0] DIG_FIVE  = 4'd5;
    localparam logic [3:0] DIG_THREE = 4'd3;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VAL_W-1:0]   r_bin;
    logic [DIG_N*4-1:0] r_bcd;
    logic [DIG_N*4-1:0] adj;

    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= DIG_FIVE) ?
                            (r_bcd[i*4 +: 4] + DIG_THREE) : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LOAD;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
            r_bcd <= {adj[DIG_N*4-2:0], r_bin[VAL_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

FILE: rtl/fse_out.sv
// ---------------------------------------------------------------------------
// fse_out
// Output register with the saturating running character count.
// ---------------------------------------------------------------------------
module fse_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_em_valid,
    input  fse_pkg::t_emit    i_em,
    output logic              o_em_rdy,
    output logic              o_valid,
    input  logic              i_stall,
    output fse_pkg::t_out_word o_data
);

    import fse_pkg::*;

    logic               r_valid;
    t_out_word          r_data;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] cnt_inc;
    logic               load;

    assign cnt_inc  = (r_cnt == {COUNT_W{1'b1}}) ? r_cnt : (r_cnt + COUNT_W'(1));
    assign o_em_rdy = !r_valid || !i_stall;
    assign load     = i_em_valid && o_em_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (o_em_rdy) begin
                r_valid <= i_em_valid;
            end
            if (load) begin
                r_cnt <= i_em.clr ? '0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_char  <= i_em.ch;
            r_data.run_last  <= i_em.last;
            r_data.out_count <= cnt_inc;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sim/format_string_expander_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// format_string_expander_tb
// Streams format, string and end words into the formatter and checks every
// emitted character word against an in-bench expansion of the same stream.
// Covers directed corner cases, a no-idle stretch of back-to-back hex
// conversions, and random format strings, with random idling on both sides.
// ---------------------------------------------------------------------------
module format_string_expander_tb;
    import fse_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;    // unused opcode, dropped by the block
    localparam logic [COUNT_W-1:0] COUNT_TOP = 16'hFFFF;
    localparam int HEX_LEN      = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_WORDS = 66;
    localparam int CALM_CONVS   = 12;

    // expands input words into the expected output words and checks them
    class fmt_scoreboard;
        bit               pct_armed;
        logic [COUNT_W-1:0] char_total = '0;
        t_out_word        expected_chars[$];
        t_out_word        fresh[$];
        int               n_in, n_ignored, n_out, n_bad;

        function void report(string what, t_out_word exp_w, t_out_word got_w);
            n_bad++;
            if (n_bad <= 10)
                $display("[%0t] %s: exp %02h/%0b/%0d got %02h/%0b/%0d (char/last/count)",
                         $realtime, what, exp_w.out_char, exp_w.run_last, exp_w.out_count,
                         got_w.out_char, got_w.run_last, got_w.out_count);
        endfunction

        function void emit_char(logic [CHAR_W-1:0] c);
            t_out_word r;
            if (char_total != COUNT_TOP)
                char_total++;
            r.out_char  = c;
            r.run_last  = 1'b0;
            r.out_count = char_total;
            fresh.push_back(r);
        endfunction

        function void emit_hex(logic [ARG_W-1:0] v);
            logic [NIB_W-1:0] nib;
            for (int i = HEX_LEN - 1; i >= 0; i--) begin
                nib = v[4*i +: 4];
                if (nib < 4'd10)
                    emit_char(CH_0 + {4'h0, nib});
                else
                    emit_char(CH_A + {4'h0, nib} - 8'd10);
            end
        endfunction

        function void emit_dec(logic [ARG_W-1:0] v);
            logic [CHAR_W-1:0] digits[10];
            logic [ARG_W-1:0]  rem;
            int                nd;
            nd = 0;
            if (v == '0) begin
                emit_char(CH_0);
                return;
            end
            while (v != '0) begin
                rem = v % 10;
                digits[nd] = CH_0 + rem[CHAR_W-1:0];
                v = v / 10;
                nd++;
            end
            for (int i = nd - 1; i >= 0; i--)
                emit_char(digits[i]);
        endfunction

        function void expand_word(t_in_word w);
            t_out_word t;
            fresh.delete();
            if (w.op == OP_NONE)
                n_ignored++;
            else
                n_in++;
            case (w.op)
                OP_FMT: begin
                    if (!pct_armed) begin
                        if (w.char_in == CH_PCT)
                            pct_armed = 1'b1;
                        else
                            emit_char(w.char_in);
                    end else begin
                        case (w.char_in)
                            CH_LX, CH_UX, CH_P: emit_hex(w.arg_value);
                            CH_D:               emit_dec(w.arg_value);
                            CH_S:               ;
                            default:            emit_char(w.char_in);
                        endcase
                        pct_armed = 1'b0;
                    end
                end
                OP_STR: begin
                    if (w.char_in != CH_NUL)
                        emit_char(w.char_in);
                end
                OP_END: begin
                    emit_char(CH_NUL);
                    pct_armed  = 1'b0;
                    char_total = '0;
                end
                default: ;
            endcase
            if (fresh.size() > 0) begin
                t = fresh.pop_back();
                t.run_last = 1'b1;
                fresh.push_back(t);
            end
            foreach (fresh[i])
                expected_chars.push_back(fresh[i]);
        endfunction

        function void check_char(t_out_word got_w);
            t_out_word exp_w;
            n_out++;
            if (expected_chars.size() == 0) begin
                report("unexpected word", '0, got_w);
                return;
            end
            exp_w = expected_chars.pop_front();
            if (got_w.out_char !== exp_w.out_char)
                report("out_char mismatch", exp_w, got_w);
            else if (got_w.run_last !== exp_w.run_last)
                report("run_last mismatch", exp_w, got_w);
            else if (got_w.out_count !== exp_w.out_count)
                report("out_count mismatch", exp_w, got_w);
        endfunction
    endclass

    logic       i_clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_word   in_data   = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_data;
    bit         calm      = 1'b0;
    int         quiet_cycles = 0;
    int         calm_words = 0;
    fmt_scoreboard sb = new();

    format_string_expander dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output side: check accepted words, stall at random outside calm stretches
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall)
            sb.check_char(o_out_data);
        out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL format_string_expander");
            $finish;
        end
    end

    task automatic drive_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                              logic [ARG_W-1:0] arg);
        t_in_word w;
        w.op        = op;
        w.char_in   = ch;
        w.arg_value = arg;
        if (!calm && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.expand_word(w);
    endtask

    task automatic drive_conv(logic [CHAR_W-1:0] conv, logic [ARG_W-1:0] arg);
        drive_word(OP_FMT, CH_PCT, $urandom);
        drive_word(OP_FMT, conv, arg);
    endtask

    // hold the sender off until every expected word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ARG_W-1:0] rand_arg();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 99);
            2:       return $urandom_range(0, 99999);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_PCT);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] conv_char();
        case ($urandom_range(0, 7))
            0:       return CH_LX;
            1:       return CH_UX;
            2:       return CH_P;
            3, 4:    return CH_D;
            5:       return CH_PCT;
            6:       return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_format();
        int kind;
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                drive_word(OP_FMT, plain_char(), $urandom);
            end else if (kind < 70) begin
                drive_conv(conv_char(), rand_arg());
            end else if (kind < 88) begin
                drive_conv(CH_S, $urandom);
                repeat ($urandom_range(0, 4))
                    drive_word(OP_STR, 8'($urandom_range(1, 255)), $urandom);
                if ($urandom_range(0, 9) != 0)
                    drive_word(OP_STR, CH_NUL, $urandom);
            end else begin
                case ($urandom_range(0, 2))
                    0:       drive_word(OP_NONE, 8'($urandom_range(0, 255)), $urandom);
                    1:       drive_word(OP_STR, 8'($urandom_range(0, 255)), $urandom);
                    default: drive_word(OP_FMT, CH_PCT, $urandom);   // left dangling
                endcase
            end
        end
        if ($urandom_range(0, 9) != 0)
            drive_word(OP_END, 8'($urandom_range(0, 255)), $urandom);
    endtask

    initial begin
        int  base;
        bit  paused;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed corners
        drive_word(OP_FMT, 8'h41, 32'h0);
        drive_word(OP_FMT, 8'hFF, 32'hFFFF_FFFF);
        drive_word(OP_FMT, CH_NUL, 32'h0);
        drive_conv(CH_LX, 32'h0123_ABCD);
        drive_conv(CH_UX, 32'hFFFF_FFFF);
        drive_conv(CH_P, 32'h0);
        drive_conv(CH_D, 32'h0);
        drive_conv(CH_D, 32'hFFFF_FFFF);
        drive_conv(CH_S, 32'h0);
        drive_word(OP_STR, 8'hFF, 32'h0);
        drive_word(OP_STR, CH_NUL, 32'h0);
        drive_conv(CH_PCT, 32'h5A5A_5A5A);
        // string byte and unused opcode while a control code is open
        drive_word(OP_FMT, CH_PCT, 32'h0);
        drive_word(OP_STR, 8'h71, 32'h0);
        drive_word(OP_NONE, 8'hFF, 32'hFFFF_FFFF);
        drive_word(OP_FMT, CH_D, 32'd1234567);
        drive_word(OP_STR, 8'h7A, 32'h0);
        drive_word(OP_FMT, CH_PCT, 32'h0);
        drive_word(OP_END, CH_NUL, 32'h0);
        drain();

        // back-to-back hex conversions, no idling on either side
        calm = 1'b1;
        base = sb.n_in;
        repeat (CALM_CONVS) drive_conv(CH_LX, $urandom);
        drive_word(OP_FMT, 8'h21, $urandom);
        drive_word(OP_STR, 8'h3F, $urandom);
        drive_word(OP_END, CH_NUL, $urandom);
        calm_words = sb.n_in - base;
        calm = 1'b0;

        // random format strings
        base   = sb.n_in;
        paused = 1'b0;
        while (sb.n_in - base < RANDOM_WORDS) begin
            random_format();
            if (!paused && sb.n_in - base >= RANDOM_WORDS / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d in the no-idle run, %0d unused-opcode words)",
                 sb.n_in + sb.n_ignored, calm_words, sb.n_ignored);
        $display("Checked %0d output words, %0d mismatches, %0d still expected",
                 sb.n_out, sb.n_bad, sb.expected_chars.size());
        if (sb.n_bad == 0 && sb.expected_chars.size() == 0)
            $display("PASS format_string_expander");
        else
            $display("FAIL format_string_expander");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/fse_pkg.sv
rtl/fse_bcd.sv
rtl/fse_out.sv
rtl/format_string_expander.sv
sim/format_string_expander_tb.sv
